FILE: src/packed_section_deframe_decrypt_assert.svh
// Assertion macros used by the core of the section deframer.
// Each macro builds one labeled concurrent assertion clocked on the rising edge.
`ifndef PACKED_SECTION_DEFRAME_DECRYPT_ASSERT_SVH
`define PACKED_SECTION_DEFRAME_DECRYPT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define PSDD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define PSDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PSDD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)
`define PSDD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: src/psdd_pkg.sv
`default_nettype none

package psdd_pkg;

   localparam logic [31:0] SIG_RESET = 32'h204B_5043;
   localparam logic [7:0]  KEY_INIT  = 8'h5F;   // low byte of 0x655F
   localparam logic [7:0]  KEY_MULT  = 8'h15;   // low byte of 0x4115
   localparam logic [3:0]  SIG_LAST  = 4'd3;    // last signature byte
   localparam logic [3:0]  HDR_LAST  = 4'd15;   // last header byte

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_BADSIG  = 2'd2,
      KIND_IGNORED = 2'd3
   } kind_type;

   typedef struct packed {
      logic       start_section;
      logic [7:0] in_byte;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic       last;
      logic [7:0] out_byte;
   } result_type;

endpackage

`default_nettype wire

FILE: src/psdd_in_stage.sv
`default_nettype none

module psdd_in_stage
   import psdd_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire item_type req_item,
   input  wire logic     fwd_ready,
   output logic          item_valid,
   output item_type      item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || fwd_ready;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !fwd_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the item while the core is stalled
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: src/psdd_core.sv
`default_nettype none

`include "packed_section_deframe_decrypt_assert.svh"

module psdd_core
   import psdd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        step,
   input  wire item_type    item,
   output result_type       result
);

   logic [31:0] expected_ff;
   phase_type   phase_ff, phase_in, phase_v;
   logic [3:0]  pos_ff, pos_in, pos_v;
   logic [31:0] sig_ff, sig_in, sig_v;
   logic [31:0] flag_ff, flag_in, flag_v;
   logic [31:0] rem_ff, rem_in, rem_v;
   logic [7:0]  key_ff, key_in, key_v;
   logic [4:0]  lane_shift;

   assign lane_shift = {pos_v[1:0], 3'b000};

   always_comb begin
      // a start marker aborts any section in progress
      phase_v = phase_ff;
      pos_v   = pos_ff;
      sig_v   = sig_ff;
      flag_v  = flag_ff;
      rem_v   = rem_ff;
      key_v   = key_ff;
      if (item.start_section) begin
         phase_v = PH_HEADER;
         pos_v   = '0;
         sig_v   = '0;
         flag_v  = '0;
         rem_v   = '0;
         key_v   = KEY_INIT;
      end

      phase_in        = phase_v;
      pos_in          = pos_v;
      sig_in          = sig_v;
      flag_in         = flag_v;
      rem_in          = rem_v;
      key_in          = key_v;
      result.kind     = KIND_IGNORED;
      result.last     = 1'b0;
      result.out_byte = '0;

      unique case (phase_v)
         PH_HEADER: begin
            result.kind = KIND_HEADER;
            case (pos_v[3:2])
               2'b00: begin
                  sig_in = {item.in_byte, sig_v[31:8]};
                  if (pos_v == SIG_LAST && sig_in != expected_ff) begin
                     result.kind = KIND_BADSIG;
                     phase_in    = PH_IDLE;
                  end
               end
               2'b01:   flag_in = flag_v | (32'(item.in_byte) << lane_shift);
               2'b10:   rem_in  = rem_v | (32'(item.in_byte) << lane_shift);
               default: ;
            endcase
            if (phase_in == PH_HEADER) begin
               if (pos_v == HDR_LAST) begin
                  key_in = KEY_INIT;
                  pos_in = '0;
                  if (rem_v == '0) begin
                     result.last = 1'b1;
                     phase_in    = PH_IDLE;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  pos_in = pos_v + 4'd1;
               end
            end
         end
         PH_PAYLOAD: begin
            result.kind     = KIND_DATA;
            result.out_byte = (flag_v == '0) ? (item.in_byte ^ key_v) : item.in_byte;
            key_in          = 8'(key_v * KEY_MULT);
            rem_in          = rem_v - 32'd1;
            if (rem_in == '0) begin
               result.last = 1'b1;
               phase_in    = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= SIG_RESET;
      end else if (csr_wr_en) begin
         expected_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         sig_ff   <= '0;
         flag_ff  <= '0;
         rem_ff   <= '0;
         key_ff   <= KEY_INIT;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sig_ff   <= sig_in;
         flag_ff  <= flag_in;
         rem_ff   <= rem_in;
         key_ff   <= key_in;
      end
   end

   `PSDD_ASSERT_NOW(a_payload_has_bytes, clock, reset, phase_ff == PH_PAYLOAD, rem_ff != '0, "payload phase with no bytes left")
   `PSDD_ASSERT_NOW(a_zero_unless_data, clock, reset, result.kind != KIND_DATA, result.out_byte == '0, "nonzero byte on a non-data result")
   `PSDD_ASSERT_NEXT(a_last_goes_idle, clock, reset, step && result.last, phase_ff == PH_IDLE, "section end did not return to idle")
   `PSDD_ASSERT_NEXT(a_badsig_goes_idle, clock, reset, step && result.kind == KIND_BADSIG, phase_ff == PH_IDLE, "signature mismatch did not return to idle")

endmodule

`default_nettype wire

FILE: src/psdd_out_stage.sv
`default_nettype none

module psdd_out_stage
   import psdd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       res_valid,
   input  wire result_type res,
   output logic            res_ready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output result_type      rsp_res
);

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign res_ready = !valid_ff || rsp_tready;
   assign valid_in  = res_valid || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

endmodule

`default_nettype wire

FILE: src/packed_section_deframe_decrypt.sv
// Channel   Direction  tdata (low bit up)  tuser            tlast
// req_      in         in_byte[7:0]        start_section    -
// rsp_      out        out_byte[7:0]       kind[1:0]        last_of_section
// csr_      in         expected_signature  -                -
//
// One byte per cycle sustained while rsp_tready stays high: every accepted byte leaves as one result.
// A byte goes from the input register to the result register; the header
// parser and key update sit between them as one step of logic.
// Synchronous active-high reset restores the signature to 0x204B5043; the parser goes idle.
// A stall on rsp_ backs up through the result and input registers in turn;
// req_tready falls only when both are full and rsp_tready is low.
`default_nettype none

module packed_section_deframe_decrypt
   import psdd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,   // expected_signature[31:0]

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // in_byte[7:0]
   input  wire logic        req_tuser,     // start_section

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,     // out_byte[7:0]
   output logic [1:0]       rsp_tuser,     // kind[1:0]
   output logic             rsp_tlast      // last_of_section
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       fwd_ready;
   logic       step;
   result_type result;
   result_type rsp_res;

   assign req_item.in_byte       = req_tdata;
   assign req_item.start_section = req_tuser;

   // input register: hold the next byte until the result register frees up
   psdd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .fwd_ready  (fwd_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   // advance the parser only when a byte moves into the result register
   assign step = item_valid && fwd_ready;

   // header parse, signature check and payload descramble
   psdd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (step),
      .item        (item),
      .result      (result)
   );

   // result register: parts the response side from the parser
   psdd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (step),
      .res        (result),
      .res_ready  (fwd_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = rsp_res.out_byte;
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tlast = rsp_res.last;

endmodule

`default_nettype wire

FILE: sim/section_descramble_checker.sv
`timescale 1ns / 1ps

module section_descramble_checker
   import psdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          mismatch_count,
   output int          outstanding,
   output int          results_checked
);

   result_type  expected_results[$];
   logic [31:0] want_sig;
   phase_type   parse_phase;
   logic [3:0]  hdr_index;
   logic [31:0] sig_window;
   logic [31:0] flag_bits;
   logic [31:0] payload_left;
   logic [7:0]  key_byte;
   int          errors;
   int          checked;

   task automatic restart_section();
      hdr_index    = '0;
      sig_window   = '0;
      flag_bits    = '0;
      payload_left = '0;
      key_byte     = KEY_INIT;
   endtask

   // Advance the deframer by one byte and return the result it produces.
   task automatic advance_deframer(input logic [7:0] b, input logic start,
                                   output result_type r);
      logic [3:0] pos;
      r.out_byte = '0;
      r.kind     = KIND_IGNORED;
      r.last     = 1'b0;
      if (start) begin
         parse_phase = PH_HEADER;
         restart_section();
      end
      case (parse_phase)
         PH_HEADER: begin
            pos    = hdr_index;
            r.kind = KIND_HEADER;
            if (pos < 4'd4) begin
               sig_window = {b, sig_window[31:8]};
               if (pos == SIG_LAST && sig_window != want_sig) begin
                  r.kind      = KIND_BADSIG;
                  parse_phase = PH_IDLE;
               end
            end else if (pos < 4'd8) begin
               flag_bits = flag_bits | (32'(b) << (8 * (pos - 4'd4)));
            end else if (pos < 4'd12) begin
               payload_left = payload_left | (32'(b) << (8 * (pos - 4'd8)));
            end
            if (parse_phase == PH_HEADER) begin
               if (pos == HDR_LAST) begin
                  key_byte  = KEY_INIT;
                  hdr_index = '0;
                  if (payload_left == '0) begin
                     r.last      = 1'b1;
                     parse_phase = PH_IDLE;
                  end else begin
                     parse_phase = PH_PAYLOAD;
                  end
               end else begin
                  hdr_index = pos + 4'd1;
               end
            end
         end
         PH_PAYLOAD: begin
            r.kind       = KIND_DATA;
            r.out_byte   = (flag_bits == '0) ? (b ^ key_byte) : b;
            key_byte     = key_byte * KEY_MULT;
            payload_left = payload_left - 32'd1;
            if (payload_left == '0) begin
               r.last      = 1'b1;
               parse_phase = PH_IDLE;
            end
         end
         default: parse_phase = PH_IDLE;
      endcase
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         expected_results.delete();
         want_sig    = SIG_RESET;
         parse_phase = PH_IDLE;
         restart_section();
         errors  = 0;
         checked = 0;
      end else begin
         if (csr_wr_en)
            want_sig = csr_wr_data;
         if (req_tvalid && req_tready) begin
            advance_deframer(req_tdata, req_tuser, want);
            expected_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("[%0t] unexpected rsp transaction: byte=%02h kind=%0d last=%0b",
                           $time, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = expected_results.pop_front();
               checked++;
               if (rsp_tdata !== want.out_byte || rsp_tuser !== want.kind ||
                   rsp_tlast !== want.last) begin
                  errors++;
                  if (errors <= 10)
                     $display("[%0t] rsp mismatch: expected byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
                              $time, want.out_byte, want.kind, want.last,
                              rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
         end
      end
      mismatch_count  <= errors;
      outstanding     <= expected_results.size();
      results_checked <= checked;
   end

endmodule

FILE: sim/packed_section_deframe_decrypt_test.sv
`timescale 1ns / 1ps

module packed_section_deframe_decrypt_test
   import psdd_pkg::*;
();

   // Cycles with no transaction on either channel before the run is declared hung.
   localparam int QUIET_LIMIT = 3000;
   // Section bytes per signature setting.
   localparam int PHASE_ITEMS = 400;
   localparam int PHASES      = 5;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int mismatch_count;
   int outstanding;
   int results_checked;

   bit sender_gaps;
   bit sink_stalls;
   int sections_sent = 0;
   int bytes_sent    = 0;
   int quiet_cycles  = 0;

   packed_section_deframe_decrypt dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // The checker sits beside the block, watches both channels and the CSR port,
   // and reports how many results were wrong and how many are still owed.
   section_descramble_checker descramble_check (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Idle length: mostly none, often short, now and then a long stretch.
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Payload sizes stay small for the most part so sections turn over quickly.
   function automatic logic [31:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return $urandom_range(1, 8);
      if (r < 80)
         return $urandom_range(0, 32);
      if (r < 95)
         return $urandom_range(33, 100);
      return $urandom_range(101, 300);
   endfunction

   function automatic logic [31:0] pick_flags();
      case ($urandom_range(0, 3))
         0, 1:    return '0;
         2:       return 32'd1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Receiver: drop tready for random stretches when stalls are enabled.
   initial begin : sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (sink_stalls)
               stall_left = pick_idle();
         end
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results still owed",
                  QUIET_LIMIT, outstanding);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one byte, optionally after an idle gap, and hold it until accepted.
   // tvalid drops here only when a gap is taken, so back-to-back bytes keep it high.
   task automatic send_byte(input logic [7:0] value, input logic start);
      int gap;
      gap = sender_gaps ? pick_idle() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Send the first hdr_len header bytes (little-endian words), then pay_len
   // random payload bytes. Short counts give truncated or aborted sections.
   task automatic send_section(input logic [31:0] sig, input logic [31:0] flags,
                               input logic [31:0] size, input logic [31:0] spare,
                               input int hdr_len, input int pay_len);
      logic [127:0] hdr;
      hdr = {spare, size, flags, sig};
      for (int i = 0; i < hdr_len; i++)
         send_byte(hdr[8*i +: 8], i == 0);
      for (int i = 0; i < pay_len; i++)
         send_byte(8'($urandom), 1'b0);
      sections_sent++;
   endtask

   // Hold off the sender until every outstanding result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Load the signature register; only called with the block drained.
   task automatic write_signature(input logic [31:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      logic [31:0] cur_sig;
      logic [31:0] size;
      logic [31:0] bad_sig;
      int          phase_items;
      int          r;
      int          n;
      bit          paused;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      sender_gaps = 1'b1;
      sink_stalls = 1'b1;

      // Directed: idle bytes at both extremes, a header cut short by a new
      // start, a wrong signature followed by an ignored byte, and an empty
      // section that ends on its last header byte. Runs on the reset signature.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_section(SIG_RESET, '0, '0, '0, 2, 0);
      send_section(SIG_RESET ^ 32'h8000_0000, '0, '0, '0, 5, 0);
      send_section(SIG_RESET, '0, '0, 32'hFFFF_FFFF, 16, 0);

      for (int p = 0; p < PHASES; p++) begin
         // Walk the register through its extremes, a random value and back.
         case (p)
            1:       cur_sig = 32'h0000_0000;
            2:       cur_sig = 32'hFFFF_FFFF;
            3:       cur_sig = $urandom;
            default: cur_sig = SIG_RESET;
         endcase
         if (p > 0)
            write_signature(cur_sig);

         // Vary backpressure per phase; one phase runs with no idling at all.
         sender_gaps = (p == 0) || (p == 2) || (p == 4);
         sink_stalls = (p == 0) || (p == 3) || (p == 4);

         phase_items = 0;
         paused      = 1'b0;
         while (phase_items < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               // Well-formed section with random content.
               size = pick_size();
               send_section(cur_sig, pick_flags(), size, $urandom, 16, int'(size));
               phase_items += 16 + int'(size);
            end else if (r < 78) begin
               // Wrong signature: header runs on, then bytes are ignored.
               bad_sig = $urandom_range(0, 1) ? (cur_sig ^ (32'd1 << $urandom_range(0, 31)))
                                              : 32'($urandom);
               send_section(bad_sig, $urandom, pick_size(), $urandom, 16,
                             $urandom_range(0, 3));
            end else if (r < 88) begin
               // Huge size, payload cut off by the next start.
               n = $urandom_range(0, 20);
               send_section(cur_sig, pick_flags(), $urandom, $urandom, 16, n);
               phase_items += 16 + n;
            end else if (r < 94) begin
               // Header abandoned partway.
               n = $urandom_range(1, 15);
               send_section(cur_sig, $urandom, $urandom, $urandom, n, 0);
               phase_items += n;
            end else begin
               // Stray bytes between sections.
               repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
            end

            if (!paused && phase_items >= PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      drain();
      repeat (10) @(posedge clock);

      $display("Sent %0d sections in %0d bytes over %0d signature settings; %0d checked.",
               sections_sent, bytes_sent, PHASES, results_checked);
      $display("Mix: good, bad-signature, truncated and aborted sections, stray bytes, %s",
               "random source gaps and sink stalls.");
      if (mismatch_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
